// File: sv/spq_pkg.sv
`default_nettype none

package spq_pkg;

  typedef enum logic [0:0] {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctrl_t;

endpackage

`default_nettype wire

// File: sv/spq_if.sv
`default_nettype none

interface spq_req_if
  import spq_pkg::*;
#(
  parameter int PAYLOAD_BITS = 32,
  parameter int PRIO_BITS    = 8
);
  logic                    valid;
  logic                    ready;
  func_e                   func;
  logic [PAYLOAD_BITS-1:0] payload;
  logic [PRIO_BITS-1:0]    prio;

  modport source (output valid, output func, output payload, output prio, input ready);
  modport sink   (input valid, input func, input payload, input prio, output ready);
  modport monitor (input valid, input ready, input func, input payload, input prio);
endinterface

interface spq_rsp_if
  import spq_pkg::*;
#(
  parameter int PAYLOAD_BITS = 32,
  parameter int CNT_BITS     = 5
);
  logic                    valid;
  logic                    ready;
  logic [PAYLOAD_BITS-1:0] out_payload;
  status_e                 status;
  logic                    is_empty;
  logic [CNT_BITS-1:0]     entry_count;

  modport source (output valid, output out_payload, output status, output is_empty,
                  output entry_count, input ready);
  modport sink   (input valid, input out_payload, input status, input is_empty,
                  input entry_count, output ready);
  modport monitor (input valid, input ready, input out_payload, input status,
                   input is_empty, input entry_count);
endinterface

`default_nettype wire

// File: sv/sorted_priority_queue.sv
`default_nettype none
// Sorted priority queue built as a row of DEPTH cells.
// Request channel req_i: func selects enqueue or dequeue; an enqueue carries
// payload and prio. Response channel rsp_o: one word per request with the
// dequeued payload (zero otherwise), status (ok, dequeue on empty, enqueue on
// full), is_empty and entry_count after the operation.
// Cell 0 holds the highest priority. On enqueue every cell compares its prio
// with the broadcast one: cells that stay keep their entry, the first cell
// that does not takes the new entry, and the ones behind it take their upper
// neighbor's entry. On dequeue every cell takes its lower neighbor's entry.
// Ties go behind stored entries, so equal priorities leave first in, first out.
// Response: the response word is registered and offered in the cycle after acceptance.
// Throughput: one request per cycle while the receiver takes responses; the whole
// row updates together, and the priority compare in each cell sets the cycle time.
// Receiver stall: the response register holds; req_i.ready drops until the
// held word is taken, so no word is lost.
// Reset: count and response valid clear; slot contents are don't-care until
// written and are only ever read below the count.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 32,
  parameter int PRIO_BITS    = 8
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  spq_req_if.sink    req_i,
  spq_rsp_if.source  rsp_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept, is_deq, full, empty;
  spq_ctrl_t        ctrl;

  logic [PRIO_BITS-1:0]    prio_w    [DEPTH];
  logic [PAYLOAD_BITS-1:0] payload_w [DEPTH];
  logic [DEPTH-1:0]        stays_w;

  // response register
  logic                    rsp_valid_q;
  logic [PAYLOAD_BITS-1:0] rsp_payload_q, rsp_payload_d;
  status_e                 rsp_status_q, rsp_status_d;
  logic                    rsp_empty_q;
  logic [CNT_W-1:0]        rsp_count_q;

  // Take a new word whenever the response slot is free or being drained.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_deq      = (req_i.func == FUNC_DEQ);
  assign full        = (cnt_q == CNT_W'(DEPTH));
  assign empty       = (cnt_q == '0);

  assign ctrl.enq = accept && !is_deq && !full;
  assign ctrl.deq = accept && is_deq && !empty;

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.enq) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (ctrl.deq) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_comb begin
    rsp_payload_d = '0;
    rsp_status_d  = ST_OK;
    if (is_deq) begin
      if (empty) begin
        rsp_status_d = ST_EMPTY;
      end else begin
        rsp_payload_d = payload_w[0];
      end
    end else if (full) begin
      rsp_status_d = ST_FULL;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    prev_stays;
    logic [PRIO_BITS-1:0]    prev_prio, next_prio;
    logic [PAYLOAD_BITS-1:0] prev_payload, next_payload;

    if (i == 0) begin : g_head
      assign prev_stays   = 1'b0;
      assign prev_prio    = req_i.prio;
      assign prev_payload = req_i.payload;
    end else begin : g_body
      assign prev_stays   = stays_w[i-1];
      assign prev_prio    = prio_w[i-1];
      assign prev_payload = payload_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // Slot past the end is empty; contents are don't-care.
      assign next_prio    = prio_w[i];
      assign next_payload = payload_w[i];
    end else begin : g_mid
      assign next_prio    = prio_w[i+1];
      assign next_payload = payload_w[i+1];
    end

    spq_cell #(
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .PRIO_BITS    (PRIO_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .occ_i          (CNT_W'(i) < cnt_q),
      .new_prio_i     (req_i.prio),
      .new_payload_i  (req_i.payload),
      .prev_stays_i   (prev_stays),
      .prev_prio_i    (prev_prio),
      .prev_payload_i (prev_payload),
      .next_prio_i    (next_prio),
      .next_payload_i (next_payload),
      .stays_o        (stays_w[i]),
      .prio_o         (prio_w[i]),
      .payload_o      (payload_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_payload_q <= rsp_payload_d;
      rsp_status_q  <= rsp_status_d;
      rsp_empty_q   <= (cnt_d == '0);
      rsp_count_q   <= cnt_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.out_payload = rsp_payload_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.is_empty    = rsp_empty_q;
  assign rsp_o.entry_count = rsp_count_q;

endmodule

`default_nettype wire

// File: sv/spq_cell.sv
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int PAYLOAD_BITS = 32,
  parameter int PRIO_BITS    = 8
) (
  input  wire                     clk_i,
  input  wire spq_ctrl_t          ctrl_i,
  input  wire                     occ_i,        // this slot holds an entry
  input  wire [PRIO_BITS-1:0]     new_prio_i,
  input  wire [PAYLOAD_BITS-1:0]  new_payload_i,
  input  wire                     prev_stays_i, // upstream neighbor keeps its entry
  input  wire [PRIO_BITS-1:0]     prev_prio_i,
  input  wire [PAYLOAD_BITS-1:0]  prev_payload_i,
  input  wire [PRIO_BITS-1:0]     next_prio_i,
  input  wire [PAYLOAD_BITS-1:0]  next_payload_i,
  output logic                    stays_o,
  output logic [PRIO_BITS-1:0]    prio_o,
  output logic [PAYLOAD_BITS-1:0] payload_o
);

  logic [PRIO_BITS-1:0]    prio_q, prio_d;
  logic [PAYLOAD_BITS-1:0] payload_q, payload_d;

  // Entry at or above the new priority stays put; ties keep arrival order.
  assign stays_o = occ_i && (prio_q >= new_prio_i);

  always_comb begin
    prio_d    = prio_q;
    payload_d = payload_q;
    if (ctrl_i.enq && !stays_o) begin
      if (prev_stays_i) begin
        prio_d    = new_prio_i;
        payload_d = new_payload_i;
      end else begin
        prio_d    = prev_prio_i;
        payload_d = prev_payload_i;
      end
    end else if (ctrl_i.deq) begin
      prio_d    = next_prio_i;
      payload_d = next_payload_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q    <= prio_d;
    payload_q <= payload_d;
  end

  assign prio_o    = prio_q;
  assign payload_o = payload_q;

endmodule

`default_nettype wire

// File: sv/spq_checker.sv
`default_nettype none

module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int CNT_W = 5
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  spq_req_if.sink     req_i,
  spq_rsp_if.source   rsp_o
);

  // Stalled response word must stay offered.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid)
    else $error("response dropped while stalled");

  // Every accepted request shows a response word on the next cycle.
  a_req_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> rsp_o.valid)
    else $error("accepted request without response");

  // Full status only when the count sits at capacity.
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == ST_FULL |-> rsp_o.entry_count == CNT_W'(DEPTH))
    else $error("full status with count below capacity");

  // Empty status means nothing stored and no payload returned.
  a_empty_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == ST_EMPTY |->
      rsp_o.entry_count == '0 && rsp_o.is_empty && rsp_o.out_payload == '0)
    else $error("empty status inconsistent");

  // is_empty flag tracks the reported count.
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.is_empty == (rsp_o.entry_count == '0))
    else $error("is_empty disagrees with entry_count");

endmodule

bind sorted_priority_queue spq_checker #(
  .DEPTH (DEPTH),
  .CNT_W (CNT_W)
) u_spq_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_o  (rsp_o)
);

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import spq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int PRIO_BITS    = 8;
  localparam int CNT_W        = 5;
  localparam int RANDOM_WORDS = 1950;
  localparam int MAX_REPORTS  = 10;
  // receiver hold-off: long enough that the response register and req ready back up
  localparam int HOLD_CYCLES  = 150;
  localparam int HOLD_EVERY   = 700;

  // one request word, or a marker telling the driver to wait until the queue drains
  typedef struct {
    bit                      pause;
    func_e                   func;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [PRIO_BITS-1:0]    prio;
  } req_word_t;

  typedef struct {
    logic [PAYLOAD_BITS-1:0] out_payload;
    status_e                 status;
    logic                    is_empty;
    logic [CNT_W-1:0]        entry_count;
  } rsp_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  spq_req_if #(.PAYLOAD_BITS(PAYLOAD_BITS), .PRIO_BITS(PRIO_BITS)) req_if ();
  spq_rsp_if #(.PAYLOAD_BITS(PAYLOAD_BITS), .CNT_BITS(CNT_W))      rsp_if ();

  sorted_priority_queue #(
    .DEPTH       (DEPTH),
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .PRIO_BITS   (PRIO_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Queue predictor: sorted copy of the stored entries, slot 0 served first.
  // --------------------------------------------------------------------------
  logic [PAYLOAD_BITS-1:0] held_payload [DEPTH];
  logic [PRIO_BITS-1:0]    held_prio    [DEPTH];
  int                      held_count = 0;

  // tallies for the closing summary
  int n_stored = 0, n_full_drops = 0, n_served = 0, n_empty_deqs = 0, peak_fill = 0;

  function automatic rsp_word_t apply_request(req_word_t w);
    rsp_word_t r;
    int        pos;
    int        i;
    r.out_payload = '0;
    r.status      = ST_OK;
    if (w.func == FUNC_ENQ) begin
      if (held_count >= DEPTH) begin
        // full: word dropped, contents untouched
        r.status = ST_FULL;
        n_full_drops++;
      end else begin
        // go behind every entry of equal or higher priority -> FIFO among ties
        pos = 0;
        while (pos < held_count && held_prio[pos] >= w.prio) pos++;
        for (i = held_count; i > pos; i--) begin
          held_payload[i] = held_payload[i-1];
          held_prio[i]    = held_prio[i-1];
        end
        held_payload[pos] = w.payload;
        held_prio[pos]    = w.prio;
        held_count++;
        n_stored++;
        if (held_count > peak_fill) peak_fill = held_count;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
      n_empty_deqs++;
    end else begin
      r.out_payload = held_payload[0];
      for (i = 0; i + 1 < held_count; i++) begin
        held_payload[i] = held_payload[i+1];
        held_prio[i]    = held_prio[i+1];
      end
      held_count--;
      n_served++;
    end
    r.is_empty    = (held_count == 0);
    r.entry_count = CNT_W'(held_count);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Shared bookkeeping
  // --------------------------------------------------------------------------
  req_word_t pending_reqs[$];   // stimulus not yet driven
  rsp_word_t expected_rsps[$];  // predicted responses, oldest first
  int        req_accepts = 0;   // request words taken by the block
  int        rsp_seen    = 0;
  int        fail_count  = 0;
  int        long_holds  = 0;
  int        drains_done = 0;

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge. The request is
  // predicted before the response is checked, so a response word offered in the
  // same cycle as its request would still line up.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    req_word_t w;
    rsp_word_t want;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        w.pause   = 1'b0;
        w.func    = req_if.func;
        w.payload = req_if.payload;
        w.prio    = req_if.prio;
        expected_rsps.push_back(apply_request(w));
        req_accepts <= req_accepts + 1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_seen <= rsp_seen + 1;
        if (expected_rsps.size() == 0) begin
          note_failure("response word with no request outstanding");
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_if.out_payload !== want.out_payload || rsp_if.status !== want.status ||
              rsp_if.is_empty !== want.is_empty || rsp_if.entry_count !== want.entry_count)
            note_failure($sformatf(
              "rsp %0d: payload %h/%h status %0d/%0d empty %b/%b count %0d/%0d (exp/act)",
              rsp_seen, want.out_payload, rsp_if.out_payload, want.status, rsp_if.status,
              want.is_empty, rsp_if.is_empty, want.entry_count, rsp_if.entry_count));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: works off pending_reqs at the falling edge in bursts with gaps.
  // A word stays on the bus until req_accepts catches up with issued. A
  // pause marker holds the bus idle until every expected response is back.
  // --------------------------------------------------------------------------
  int issued     = 0;
  int burst_left = 8;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    req_word_t w;
    if (rst_ni && !(req_if.valid && req_accepts != issued)) begin
      if (gap_left > 0) begin
        req_if.valid <= 1'b0;
        gap_left     <= gap_left - 1;
      end else if (pending_reqs.size() == 0) begin
        req_if.valid <= 1'b0;
      end else if (pending_reqs[0].pause) begin
        req_if.valid <= 1'b0;
        if (expected_rsps.size() == 0) begin
          void'(pending_reqs.pop_front());
          drains_done++;
        end
      end else begin
        w = pending_reqs.pop_front();
        req_if.valid   <= 1'b1;
        req_if.func    <= w.func;
        req_if.payload <= w.payload;
        req_if.prio    <= w.prio;
        issued         <= issued + 1;
        if (burst_left <= 1) begin
          // now and then a long burst with no idling at all
          burst_left <= ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready pattern switches between randomly chosen modes. After 400
  // accepted requests, and then every HOLD_EVERY more, it holds ready low while the
  // driver keeps offering, so the block backs up and stalls its input.
  // --------------------------------------------------------------------------
  int hold_left    = 0;
  int next_hold_at = 400;
  int stall_mode   = 0;
  int mode_left    = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        rsp_if.ready  <= 1'b0;
      end else if (req_accepts >= next_hold_at) begin
        hold_left     <= HOLD_CYCLES;
        next_hold_at  <= next_hold_at + HOLD_EVERY;
        long_holds    <= long_holds + 1;
        rsp_if.ready  <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= $urandom_range(0, 3);
          mode_left  <= $urandom_range(16, 96);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
          2:       rsp_if.ready <= 1'($urandom_range(0, 1));
          default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic add_req(input func_e f, input logic [PAYLOAD_BITS-1:0] pay,
                         input logic [PRIO_BITS-1:0] pr);
    req_word_t w;
    w.pause   = 1'b0;
    w.func    = f;
    w.payload = pay;
    w.prio    = pr;
    pending_reqs.push_back(w);
  endtask

  task automatic add_drain();
    req_word_t w;
    w.pause   = 1'b1;
    w.func    = FUNC_ENQ;
    w.payload = '0;
    w.prio    = '0;
    pending_reqs.push_back(w);
  endtask

  task automatic build_stimulus();
    int n_random;
    int seg_len;
    int enq_pct;
    int prio_style;
    int k;
    logic [PRIO_BITS-1:0] pr;
    // directed: dequeue on empty, priority and payload extremes, ties leave FIFO
    add_req(FUNC_DEQ, 32'hDEAD_BEEF, 8'h5A);
    add_req(FUNC_ENQ, 32'hFFFF_FFFF, 8'hFF);
    add_req(FUNC_ENQ, 32'h0000_0000, 8'h00);
    add_req(FUNC_ENQ, 32'hA5A5_0001, 8'h07);
    add_req(FUNC_ENQ, 32'hA5A5_0002, 8'h07);
    add_req(FUNC_ENQ, 32'hA5A5_0003, 8'h07);
    add_req(FUNC_ENQ, 32'h5A5A_5A5A, 8'h80);
    add_req(FUNC_ENQ, 32'h0000_0011, 8'hFF);  // ties with the head, goes behind it
    for (k = 0; k < 8; k++) add_req(FUNC_DEQ, $urandom(), PRIO_BITS'($urandom()));
    add_drain();

    // random: segments with a fill bias, so the queue swings between full and empty
    n_random = 0;
    while (n_random < RANDOM_WORDS) begin
      seg_len    = $urandom_range(20, 60);
      prio_style = $urandom_range(0, 2);
      case ($urandom_range(0, 4))
        0:       enq_pct = 90;
        1:       enq_pct = 70;
        2:       enq_pct = 50;
        3:       enq_pct = 30;
        default: enq_pct = 10;
      endcase
      for (k = 0; k < seg_len; k++) begin
        case (prio_style)
          0:       pr = PRIO_BITS'($urandom_range(0, 255));
          1:       pr = PRIO_BITS'($urandom_range(0, 3));            // many ties
          default: pr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
        add_req(($urandom_range(1, 100) <= enq_pct) ? FUNC_ENQ : FUNC_DEQ, $urandom(), pr);
        n_random++;
      end
      if ($urandom_range(0, 5) == 0) add_drain();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, run, drain, verdict.
  // --------------------------------------------------------------------------
  initial begin
    int wait_cycles;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.func    = FUNC_ENQ;
    req_if.payload = '0;
    req_if.prio    = '0;
    rsp_if.ready   = 1'b0;
    build_stimulus();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || req_if.valid) @(posedge clk_i);
    for (wait_cycles = 0; wait_cycles < 20000 && expected_rsps.size() != 0; wait_cycles++)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (expected_rsps.size() != 0)
      note_failure($sformatf("%0d responses never arrived", expected_rsps.size()));

    $display("Ran %0d requests: %0d stored, %0d refused full, %0d served, %0d on empty",
             req_accepts, n_stored, n_full_drops, n_served, n_empty_deqs);
    $display("Peak fill %0d of %0d, %0d long receiver stalls, %0d drains, %0d failures",
             peak_fill, DEPTH, long_holds, drains_done, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
